// ===== rtl/bbl_pkg.sv =====
// Shared types and constants of the per-type byte budget limiter.
// Used by bbl_update, per_type_byte_budget_limiter and the testbench; depends on nothing.
`default_nettype none

package bbl_pkg;

  // Size of the per-type table
  localparam int TYPE_SLOTS = 131072;
  localparam int SLOT_BITS  = $clog2(TYPE_SLOTS);

  // Field widths
  localparam int TYPE_W   = 17;
  localparam int STAMP_W  = 32;
  localparam int LEN_W    = 16;
  localparam int BUDGET_W = 16;
  localparam int HDR_W    = 8;
  localparam int COUNT_W  = 32;
  localparam int COST_W   = LEN_W + 1;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd2;
  localparam logic [TYPE_W-1:0]   TYPE_LIMIT_RST   = 17'd100000;
  localparam logic [BUDGET_W-1:0] BUDGET_BYTES_RST = 16'd2048;
  localparam logic [HDR_W-1:0]    HEADER_BYTES_RST = 8'd12;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DROP = 2'd1,
    STAT_OVER = 2'd2
  } status_t;

  // Control states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // One table entry
  typedef struct packed {
    logic                valid;
    logic [BUDGET_W-1:0] budget;
    logic [STAMP_W-1:0]  stamp;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Configuration seen by the update logic
  typedef struct packed {
    logic [TYPE_W-1:0]   type_limit;
    logic [BUDGET_W-1:0] budget_bytes;
    logic [HDR_W-1:0]    header_bytes;
  } cfg_t;

  // Message held while it is worked on
  typedef struct packed {
    logic [TYPE_W-1:0]  mtype;
    logic [STAMP_W-1:0] stamp;
    logic [LEN_W-1:0]   length;
  } msg_t;

  // Result of one message plus the write-back decision
  typedef struct packed {
    logic                write;
    logic                accepted;
    status_t             status;
    logic [BUDGET_W-1:0] remaining;
    logic [COUNT_W-1:0]  count;
    logic                first;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bbl_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data; no dependencies.
`default_nettype none

module bbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbl_update.sv =====
// Read-modify-write logic for one table entry: refill, fit check, count.
// Depends on bbl_pkg.
`default_nettype none

module bbl_update
  import bbl_pkg::*;
(
  input  wire cfg_t    cfg,
  input  wire msg_t    msg,
  input  wire entry_t  entry_in,
  output      entry_t  entry_out,
  output      result_t result
);

  entry_t            cur;
  logic              first;
  logic              drop;
  logic [COST_W-1:0] cost;
  logic              fit;

  always_comb begin
    // Drop types above the limit or beyond the table
    drop = (msg.mtype > cfg.type_limit) ||
           ({{(32-TYPE_W){1'b0}}, msg.mtype} >= 32'(TYPE_SLOTS));

    // Create a first-seen entry, reload the budget on a new time stamp
    cur   = entry_in;
    first = 1'b0;
    if (!entry_in.valid) begin
      cur.valid  = 1'b1;
      cur.budget = cfg.budget_bytes;
      cur.stamp  = msg.stamp;
      cur.count  = '0;
      first      = 1'b1;
    end else if (entry_in.stamp != msg.stamp) begin
      cur.budget = cfg.budget_bytes;
      cur.stamp  = msg.stamp;
    end

    // Check the fit and deduct
    cost = {{(COST_W-HDR_W){1'b0}}, cfg.header_bytes} + {1'b0, msg.length};
    fit  = cost <= {1'b0, cur.budget};

    entry_out = cur;
    if (fit) begin
      entry_out.budget = cur.budget - cost[BUDGET_W-1:0];
      if (cur.count != '1) begin
        entry_out.count = cur.count + 1'b1;
      end
    end

    // Build the result
    result.write = !drop;
    if (drop) begin
      result.accepted  = 1'b0;
      result.status    = STAT_DROP;
      result.remaining = '0;
      result.count     = '0;
      result.first     = 1'b0;
    end else begin
      result.accepted  = fit;
      result.status    = fit ? STAT_OK : STAT_OVER;
      result.remaining = entry_out.budget;
      result.count     = entry_out.count;
      result.first     = first;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/per_type_byte_budget_limiter.sv =====
// Per-type byte budget limiter: every message costs header_bytes plus its payload
// length, and each type may spend budget_bytes per time stamp. A message is taken in
// ST_IDLE, where the type's entry is read from the table memory; in ST_EXEC the entry
// is updated, written back and the result register loaded; a held result stalls
// ST_EXEC. After reset a clearing pass writes every one of the TYPE_SLOTS entries,
// one per cycle, and no message is taken until it ends; configuration writes are
// taken at any time. Depends on bbl_pkg, bbl_ram and bbl_update.
`default_nettype none

module per_type_byte_budget_limiter
  import bbl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Message request
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [TYPE_W-1:0]    message_type,
  input  wire logic [STAMP_W-1:0]   time_stamp,
  input  wire logic [LEN_W-1:0]     payload_length,
  // Result request
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic                 accepted,
  output      logic [1:0]           status,
  output      logic [BUDGET_W-1:0]  remaining_budget,
  output      logic [COUNT_W-1:0]   type_count,
  output      logic                 first_seen
);

  state_t               state, state_next;
  cfg_t                 cfg;
  msg_t                 msg;
  logic [SLOT_BITS-1:0] clr_addr;
  logic                 in_take;
  logic                 exec_go;
  logic                 clr_last;

  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;
  entry_t               upd_entry;
  result_t              upd_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_limit   <= TYPE_LIMIT_RST;
      cfg.budget_bytes <= BUDGET_BYTES_RST;
      cfg.header_bytes <= HEADER_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TYPE_LIMIT:   cfg.type_limit   <= cfg_data[TYPE_W-1:0];
        CFG_BUDGET_BYTES: cfg.budget_bytes <= cfg_data[BUDGET_W-1:0];
        CFG_HEADER_BYTES: cfg.header_bytes <= cfg_data[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake conditions
  assign in_ready = (state == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign exec_go  = (state == ST_EXEC) && (!out_valid || out_ready);
  assign clr_last = (clr_addr == SLOT_BITS'(TYPE_SLOTS - 1));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (in_take)  state_next = ST_EXEC;
      ST_EXEC:  if (exec_go)  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Advance the clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Hold the accepted message
  always_ff @(posedge clk) begin
    if (in_take) begin
      msg.mtype  <= message_type;
      msg.stamp  <= time_stamp;
      msg.length <= payload_length;
    end
  end

  // Table memory
  bbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TYPE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_take),
    .raddr (message_type[SLOT_BITS-1:0]),
    .rdata (ram_rdata)
  );

  bbl_update u_update (
    .cfg       (cfg),
    .msg       (msg),
    .entry_in  (ram_rdata),
    .entry_out (upd_entry),
    .result    (upd_res)
  );

  // Select clearing writes or the write-back of an updated entry
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = exec_go && upd_res.write;
      ram_waddr = msg.mtype[SLOT_BITS-1:0];
      ram_wdata = upd_entry;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (exec_go) begin
      accepted         <= upd_res.accepted;
      status           <= upd_res.status;
      remaining_budget <= upd_res.remaining;
      type_count       <= upd_res.count;
      first_seen       <= upd_res.first;
    end
  end

  // No message is taken during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("message taken during table clear");

  // An accepted message goes to the update cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_EXEC))
    else $error("accepted message not processed");

  // An accepted result always carries a nonzero count and status ok
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (type_count != '0 && status == STAT_OK))
    else $error("accepted result with bad count or status");

  // A dropped result never touches the table
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && upd_res.status == STAT_DROP) |-> !ram_we)
    else $error("dropped message written to table");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for per_type_byte_budget_limiter: a budget ledger class predicts
// every result from the requests it sees accepted; plain tasks drive requests and registers.
// Depends on bbl_pkg and the block's RTL only.
`timescale 1ns / 100ps

import bbl_pkg::*;

// Predict the limiter's results and check them in order
class budget_ledger;
  typedef struct {
    logic                accepted;
    status_t             status;
    logic [BUDGET_W-1:0] remaining;
    logic [COUNT_W-1:0]  count;
    logic                first;
  } verdict_t;

  typedef struct {
    logic [BUDGET_W-1:0] budget;
    logic [STAMP_W-1:0]  stamp;
    logic [COUNT_W-1:0]  count;
  } slot_t;

  logic [TYPE_W-1:0]   type_limit;
  logic [BUDGET_W-1:0] budget_bytes;
  logic [HDR_W-1:0]    header_bytes;
  slot_t               slots [int unsigned];
  verdict_t            verdicts_due [$];
  int                  faults;
  int                  reported;

  function new();
    type_limit   = TYPE_LIMIT_RST;
    budget_bytes = BUDGET_BYTES_RST;
    header_bytes = HEADER_BYTES_RST;
    faults       = 0;
    reported     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    case (index)
      CFG_TYPE_LIMIT:   type_limit   = data[TYPE_W-1:0];
      CFG_BUDGET_BYTES: budget_bytes = data[BUDGET_W-1:0];
      CFG_HEADER_BYTES: header_bytes = data[HDR_W-1:0];
      default: ;  // unmapped index: the block ignores the write
    endcase
  endfunction

  // Append one expected result at the tail of the queue
  function void queue_verdict(verdict_t v);
    verdicts_due = {verdicts_due, v};
  endfunction

  // Work out the result of one accepted request and update the type's entry
  function void note_message(logic [TYPE_W-1:0] mtype, logic [STAMP_W-1:0] stamp,
                             logic [LEN_W-1:0] length);
    verdict_t    v;
    slot_t       s;
    int unsigned cost;
    int unsigned key;
    key = 32'(mtype);
    v = '{accepted: 1'b0, status: STAT_DROP, remaining: '0, count: '0, first: 1'b0};
    // Drop types above the limit or past the table; leave the table alone
    if (mtype > type_limit || key >= TYPE_SLOTS) begin
      queue_verdict(v);
      return;
    end
    // Create a first-seen entry, or reload the budget on a new time stamp
    if (!slots.exists(key)) begin
      s.budget = budget_bytes;
      s.stamp  = stamp;
      s.count  = '0;
      v.first  = 1'b1;
    end else begin
      s = slots[key];
      if (s.stamp != stamp) begin
        s.budget = budget_bytes;
        s.stamp  = stamp;
      end
    end
    cost = header_bytes + length;
    if (cost > s.budget) begin
      v.status = STAT_OVER;
    end else begin
      s.budget = s.budget - BUDGET_W'(cost);
      if (s.count != '1) s.count = s.count + 1'b1;
      v.accepted = 1'b1;
      v.status   = STAT_OK;
    end
    v.remaining = s.budget;
    v.count     = s.count;
    slots[key]  = s;
    queue_verdict(v);
  endfunction

  function void check_verdict(logic got_acc, logic [1:0] got_status,
                              logic [BUDGET_W-1:0] got_rem, logic [COUNT_W-1:0] got_count,
                              logic got_first);
    verdict_t v;
    if (verdicts_due.size() == 0) begin
      report($sformatf("result with nothing expected: acc=%0b st=%0d rem=%0d cnt=%0d first=%0b",
                       got_acc, got_status, got_rem, got_count, got_first));
      return;
    end
    v = verdicts_due.pop_front();
    if (got_acc !== v.accepted || got_status !== v.status || got_rem !== v.remaining ||
        got_count !== v.count || got_first !== v.first)
      report($sformatf({"result mismatch: expected acc=%0b st=%0d rem=%0d cnt=%0d first=%0b,",
                        " got acc=%0b st=%0d rem=%0d cnt=%0d first=%0b"},
                       v.accepted, v.status, v.remaining, v.count, v.first,
                       got_acc, got_status, got_rem, got_count, got_first));
  endfunction

  function int pending();
    return verdicts_due.size();
  endfunction

  // Count every fault; print only the first ten
  function void report(string what);
    faults++;
    if (reported < 10) begin
      reported++;
      $display("%0t: %s", $time, what);
    end
  endfunction
endclass

module testbench;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int HOLDOFF_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [TYPE_W-1:0]    message_type = '0;
  logic [STAMP_W-1:0]   time_stamp = '0;
  logic [LEN_W-1:0]     payload_length = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 accepted;
  logic [1:0]           status;
  logic [BUDGET_W-1:0]  remaining_budget;
  logic [COUNT_W-1:0]   type_count;
  logic                 first_seen;

  budget_ledger ledger;
  int           sender_idle_pct = 0;
  int           stall_pct = 0;
  logic         holding = 1'b0;
  event         start_holdoff;

  per_type_byte_budget_limiter dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .message_type    (message_type),
    .time_stamp      (time_stamp),
    .payload_length  (payload_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .status          (status),
    .remaining_budget(remaining_budget),
    .type_count      (type_count),
    .first_seen      (first_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive result ready: hold it low during a hold-off, else stall at random
  always @(negedge clk) begin
    out_ready <= !holding && ($urandom_range(0, 99) >= stall_pct);
  end

  // Count out one long receiver hold-off per trigger
  initial begin
    forever begin
      @(start_holdoff);
      holding = 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  // Check every accepted result request
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      ledger.check_verdict(accepted, status, remaining_budget, type_count, first_seen);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one message request after an optional idle gap; note it once accepted
  task automatic offer(input logic [TYPE_W-1:0] mtype, input logic [STAMP_W-1:0] stamp,
                       input logic [LEN_W-1:0] length);
    int gap;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    message_type   <= mtype;
    time_stamp     <= stamp;
    payload_length <= length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ledger.note_message(mtype, stamp, length);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    ledger.write_reg(index, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic over a small pool of types so entries get reused and run dry
  task automatic run_traffic(input int count);
    logic [TYPE_W-1:0]  pool [8];
    logic [STAMP_W-1:0] stamp;
    logic [TYPE_W-1:0]  mtype;
    logic [LEN_W-1:0]   length;
    stamp = $urandom;
    foreach (pool[k]) pool[k] = TYPE_W'($urandom_range(0, ledger.type_limit));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 8) mtype = TYPE_W'($urandom_range(0, 131071));
      else mtype = pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 19) == 0) stamp = stamp + 1'b1;
      else if ($urandom_range(0, 49) == 0) stamp = $urandom;
      if ($urandom_range(0, 7) == 0) length = LEN_W'($urandom);
      else length = LEN_W'($urandom_range(0, ledger.budget_bytes / 4 + 4));
      offer(mtype, stamp, length);
    end
  endtask

  initial begin
    ledger = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings; the clearing pass holds off the first request
    offer(17'd0, 32'd0, 16'd0);                     // first sight, accepted
    offer(17'd0, 32'd0, 16'd2024);                  // exact fit, leaves zero
    offer(17'd0, 32'd0, 16'd0);                     // over budget on an empty budget
    offer(17'd0, 32'd1, 16'd0);                     // time change reloads the budget
    offer(17'd100000, 32'hFFFF_FFFF, 16'hFFFF);     // first sight, then rejected
    offer(17'd100000, 32'hFFFF_FFFF, 16'd100);      // entry stays created
    offer(17'd100001, 32'h5555_AAAA, 16'd7);        // type above limit
    offer(17'h1FFFF, 32'hAAAA_5555, 16'd0);         // top type, dropped
    offer(17'd5, 32'd7, 16'hFFFF);                  // first sight, over budget
    offer(17'd5, 32'd8, 16'hFFFF);                  // time change, still over budget
    offer(17'd5, 32'd8, 16'd1);                     // accepted in the new window
    run_traffic(90);
    // Hold results back long enough to stall requests
    -> start_holdoff;
    run_traffic(60);
    drain();

    // Extremes of the registers
    set_register(CFG_TYPE_LIMIT, 17'h1FFFF);
    set_register(CFG_BUDGET_BYTES, 17'h0FFFF);
    set_register(CFG_HEADER_BYTES, 17'd0);
    offer(17'h1FFFF, 32'hFFFF_FFFF, 16'hFFFF);      // full budget spent exactly
    offer(17'h1FFFF, 32'hFFFF_FFFF, 16'd0);         // zero cost fits a zero budget
    drain();
    set_register(CFG_HEADER_BYTES, 17'h000FF);
    offer(17'h1FFFF, 32'd0, 16'hFFFF);              // cost beyond 16 bits
    drain();
    set_register(CFG_TYPE_LIMIT, 17'd0);
    set_register(CFG_BUDGET_BYTES, 17'd0);
    set_register(CFG_HEADER_BYTES, 17'd0);
    offer(17'd0, 32'd2, 16'd0);                     // zero budget, zero cost
    offer(17'd1, 32'd2, 16'd0);                     // limit zero drops type one
    offer(17'd0, 32'd2, 16'd1);                     // zero budget, over
    drain();

    // Phase: sender idles, wide limits and budget
    set_register(CFG_TYPE_LIMIT, 17'h1FFFF);
    set_register(CFG_BUDGET_BYTES, 17'h0FFFF);
    set_register(CFG_HEADER_BYTES, 17'd0);
    set_register(2'd3, CFG_W'($urandom));           // unmapped index, ignored
    sender_idle_pct = 56;
    stall_pct       = 0;
    run_traffic(175);
    drain();

    // Phase: receiver stalls, tight budget with a heavy header
    set_register(CFG_TYPE_LIMIT, CFG_W'($urandom_range(1, 131071)));
    set_register(CFG_BUDGET_BYTES, 17'd300);
    set_register(CFG_HEADER_BYTES, 17'd255);
    sender_idle_pct = 0;
    stall_pct       = 56;
    run_traffic(175);
    drain();

    // Phase: both sides idle, random settings
    set_register(CFG_TYPE_LIMIT, CFG_W'($urandom_range(1000, 131071)));
    set_register(CFG_BUDGET_BYTES, CFG_W'($urandom_range(0, 65535)));
    set_register(CFG_HEADER_BYTES, CFG_W'($urandom_range(0, 255)));
    sender_idle_pct = 25;
    stall_pct       = 25;
    run_traffic(175);
    drain();

    repeat (8) @(posedge clk);
    if (ledger.faults == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
